FILE: rtl/core/tspm_pkg.sv
// Package for the take/skip position mapper: word types, opcodes, constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tspm_pkg;

  localparam int unsigned FieldW  = 31;
  localparam int unsigned KeepW   = 16;
  localparam int unsigned PeriodW = 17;
  localparam int unsigned ProdW   = FieldW + PeriodW;
  localparam int unsigned PosWidthDefault = 31;

  typedef enum logic [1:0] {
    OP_V2R_POS  = 2'd0,
    OP_R2V_POS  = 2'd1,
    OP_R2V_SIZE = 2'd2,
    OP_V2R_SIZE = 2'd3
  } opcode_t;

  typedef enum logic {
    CFG_KEEP = 1'b0,
    CFG_DROP = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [FieldW-1:0]   operand_value;
  } in_word_t;

  typedef struct packed {
    logic [FieldW-1:0]   mapped_value;
    logic                error_flag;
  } out_word_t;

  typedef struct packed {
    logic                vld;
    opcode_t             op;
    logic [KeepW-1:0]    take;
    logic [PeriodW-1:0]  per;
    logic [PeriodW-1:0]  div;
    logic [PeriodW-1:0]  rem;
    logic [FieldW-1:0]   acc;
    logic                err;
    logic                lt;
  } cell_word_t;

endpackage
`default_nettype wire

FILE: rtl/core/tspm_div_cell.sv
// One restoring-division cell: retires one quotient bit per word.
// Depends on tspm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tspm_div_cell import tspm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       en,
  input  wire cell_word_t d_in,
  output cell_word_t      d_out
);

  cell_word_t          cell_r;
  cell_word_t          cell_nxt;
  logic [PeriodW:0]    trial;
  logic                ge;

  always_comb begin
    trial    = {d_in.rem, d_in.acc[FieldW-1]};
    ge       = trial >= {1'b0, d_in.div};
    cell_nxt = d_in;
    cell_nxt.rem = ge ? PeriodW'(trial - {1'b0, d_in.div}) : trial[PeriodW-1:0];
    cell_nxt.acc = {d_in.acc[FieldW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign d_out = cell_r;

endmodule
`default_nettype wire

FILE: rtl/core/take_skip_position_mapper.sv
// Top level of the take/skip position mapper: divider cell chain, multiply, output.
// Depends on tspm_pkg and tspm_div_cell.
//
//  channel | ports                               | moves
//  in      | in_valid, in_ready, in_data         | opcode, operand_value
//  out     | out_valid, out_ready, out_data      | mapped_value, error_flag
//  cfg     | cfg_we, cfg_index, cfg_data         | keep_count, drop_count
//
// One word per cycle while the output is not stalled; 31 divider cells, multiply, add/check.
// The whole pipeline advances together whenever the output register is free or taken.
// Reset (rst_n low, synchronous) empties the pipeline; keep_count and drop_count go to 1.
`timescale 1ns / 1ps
`default_nettype none
module take_skip_position_mapper import tspm_pkg::*; #(
  parameter int unsigned POS_WIDTH = PosWidthDefault
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_word_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_word_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [KeepW-1:0] cfg_data
);

  localparam logic [FieldW-1:0] Lim =
    (POS_WIDTH >= FieldW) ? {FieldW{1'b1}} : FieldW'((64'd1 << POS_WIDTH) - 64'd1);

  logic [KeepW-1:0]   keep_r;
  logic [KeepW-1:0]   drop_r;
  logic               en;
  cell_word_t         chain [0:FieldW];
  cell_word_t         head;
  cell_word_t         tail;
  logic               m_vld_r;
  logic [ProdW-1:0]   prod_r;
  logic [PeriodW-1:0] add_r;
  logic               m_err_r;
  logic [ProdW:0]     sum;
  logic               out_valid_r;
  out_word_t          out_r;
  logic               fin_err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= KeepW'(1);
      drop_r <= KeepW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEEP: keep_r <= cfg_data;
        CFG_DROP: drop_r <= cfg_data;
        default:  keep_r <= keep_r;
      endcase
    end
  end

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_comb begin
    head      = '0;
    head.vld  = in_valid;
    head.op   = in_data.opcode;
    head.take = keep_r;
    head.per  = PeriodW'({1'b0, keep_r} + {1'b0, drop_r});
    head.div  = (in_data.opcode == OP_V2R_POS || in_data.opcode == OP_V2R_SIZE) ?
                {1'b0, keep_r} : head.per;
    head.rem  = '0;
    head.acc  = in_data.operand_value;
    head.err  = (keep_r == '0) || (in_data.operand_value > Lim);
    head.lt   = in_data.operand_value < {{(FieldW-KeepW){1'b0}}, keep_r};
  end

  assign chain[0] = head;

  for (genvar g = 0; g < FieldW; g++) begin : g_cell
    tspm_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_in  (chain[g]),
      .d_out (chain[g+1])
    );
  end

  assign tail = chain[FieldW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= tail.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= ProdW'(tail.acc) *
                ((tail.op == OP_V2R_POS || tail.op == OP_V2R_SIZE) ?
                 ProdW'(tail.per) : ProdW'(tail.take));
      case (tail.op)
        OP_V2R_POS: add_r <= tail.rem;
        OP_R2V_POS: add_r <= (tail.rem < {1'b0, tail.take}) ? tail.rem : {1'b0, tail.take};
        default:    add_r <= '0;
      endcase
      m_err_r <= tail.err ||
                 ((tail.op == OP_R2V_SIZE || tail.op == OP_V2R_SIZE) &&
                  (tail.lt || tail.rem != '0));
    end
  end

  always_comb begin
    sum     = {1'b0, prod_r} + (ProdW+1)'(add_r);
    fin_err = m_err_r || (sum > (ProdW+1)'(Lim));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.error_flag   <= fin_err;
      out_r.mapped_value <= fin_err ? '0 : sum[FieldW-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

FILE: rtl/core/tspm_checker.sv
// Port-level checker for take_skip_position_mapper, with its bind.
// Depends on tspm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tspm_checker import tspm_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word dropped or changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error_flag |-> out_data.mapped_value == '0)
    else $error("error word carries nonzero value");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input stalled while output free");

endmodule

bind take_skip_position_mapper tspm_checker u_tspm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

FILE: tb/tb.sv
// Testbench for take_skip_position_mapper: drives conversion words, predicts each
// result from the current keep/drop counts, and compares in order. Depends on tspm_pkg.
`timescale 1ns / 1ps
module tb;
  import tspm_pkg::*;

  localparam int unsigned LATENCY   = 33;
  localparam longint      CYCLE_CAP = 400000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_word_t out_data;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [KeepW-1:0] cfg_data = '0;

  take_skip_position_mapper dut (.*);

  logic [15:0] keep_now = 1, drop_now = 1;
  out_word_t expected_q[$];
  int err_count = 0;
  longint cycles = 0;
  bit steady = 0;

  initial forever #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic out_word_t map_word(in_word_t w);
    longint unsigned p, take, per, res, rem, lim;
    bit bad;
    out_word_t r;
    p = w.operand_value;
    take = keep_now;
    per = keep_now + drop_now;
    lim = 64'h7FFF_FFFF;
    res = 0;
    bad = 0;
    if (take == 0) bad = 1;
    else case (w.opcode)
      OP_V2R_POS: res = (p / take) * per + p % take;
      OP_R2V_POS: begin
        rem = p % per;
        res = (p / per) * take + (rem < take ? rem : take);
      end
      OP_R2V_SIZE: begin
        if (p < take || p % per != 0) bad = 1;
        else res = (p / per) * take;
      end
      default: begin
        if (p < take || p % take != 0) bad = 1;
        else res = (p / take) * per;
      end
    endcase
    if (!bad && res > lim) bad = 1;
    r.mapped_value = bad ? '0 : res[30:0];
    r.error_flag = bad;
    return r;
  endfunction

  // result checker with random stall
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result word %h", out_data);
        err_count++;
      end else begin
        e = expected_q.pop_front();
        if (out_data.mapped_value !== e.mapped_value) begin
          $error("mapped_value expected %0d actual %0d", e.mapped_value,
                 out_data.mapped_value);
          err_count++;
        end
        if (out_data.error_flag !== e.error_flag) begin
          $error("error_flag expected %0d actual %0d", e.error_flag, out_data.error_flag);
          err_count++;
        end
      end
    end
    out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 31);
  end

  task automatic send_word(opcode_t op, logic [30:0] v);
    if (!steady)
      while ($urandom_range(99) < 31) begin
        in_valid <= 0;
        @(posedge clk);
      end
    in_valid <= 1;
    in_data <= '{opcode: op, operand_value: v};
    expected_q.push_back(map_word('{opcode: op, operand_value: v}));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_counts(logic [15:0] k, logic [15:0] d);
    cfg_we <= 1; cfg_index <= CFG_KEEP; cfg_data <= k;
    @(posedge clk);
    cfg_index <= CFG_DROP; cfg_data <= d;
    @(posedge clk);
    cfg_we <= 0;
    keep_now = k;
    drop_now = d;
  endtask

  task automatic test_directed();
    opcode_t op;
    for (int i = 0; i < 4; i++) begin
      op = opcode_t'(i);
      send_word(op, 0);
      send_word(op, 31'h7FFF_FFFF);
      send_word(op, 6);
      send_word(op, 7);
    end
    drain();
    set_counts(0, 5);
    send_word(OP_V2R_POS, 9);
    send_word(OP_R2V_SIZE, 10);
    drain();
    set_counts(16'hFFFF, 16'hFFFF);
    send_word(OP_V2R_POS, 31'h7FFF_FFFF);
    send_word(OP_V2R_SIZE, 31'(65535 * 300));
    send_word(OP_R2V_SIZE, 31'(131070 * 5));
    send_word(OP_R2V_POS, 31'(131070 * 5 + 70000));
    send_word(OP_V2R_SIZE, 100);
    drain();
  endtask

  task automatic test_random(int n);
    logic [30:0] v;
    opcode_t op;
    for (int i = 0; i < n; i++) begin
      op = opcode_t'($urandom_range(3));
      case ($urandom_range(3))
        0: v = 31'($urandom);
        1: v = 31'($urandom_range(200));
        // multiples of keep or period so size conversions can succeed
        2: v = 31'((keep_now + drop_now) * $urandom_range(5000));
        default: v = 31'(keep_now * $urandom_range(5000));
      endcase
      send_word(op, v);
    end
  endtask

  task automatic test_settings();
    logic [15:0] k, d;
    for (int s = 0; s < 8; s++) begin
      k = (s % 3 == 0) ? 16'($urandom_range(16'hFFFF)) : 16'($urandom_range(1, 9));
      d = (s == 2) ? 16'd0 : ((s == 5) ? 16'hFFFF : 16'($urandom_range(0, 12)));
      set_counts(k, d);
      test_random(240);
      drain();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_settings();
    set_counts(3, 2);
    steady = 1;
    test_random(150);
    steady = 0;
    test_random(100);
    drain();
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
